// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands shared by the checker files.
// Both forms sample on the rising edge of clk and are held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/utbd_pkg.sv -----
`timescale 1ns / 1ps

package utbd_pkg;

  // Bits of the input value taken into the conversion (8..64).
  localparam int VALUE_WIDTH = 64;

  // Divider: dividend bits retired per cycle, divider steps per digit.
  localparam int STEP_BITS = 8;
  localparam int STEPS     = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W     = STEPS * STEP_BITS;
  localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Digit store.
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

  localparam int RADIX_MIN = 2;
  localparam int RADIX_MAX = 16;

  localparam logic [6:0] GLYPH_UPPER [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };
  localparam logic [6:0] GLYPH_LOWER [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new item
    logic step;      // run one divider step
    logic commit;    // store the finished digit, restart the divider
    logic fetch;     // read the digit at the emit pointer
    logic advance;   // move the emit pointer toward the low digit
    logic show_err;  // present the bad-base result
  } utbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic radix_bad;   // base on the input port is out of range
    logic step_done;   // this step finishes the current digit
    logic quo_zero;    // quotient is exhausted
    logic count_full;  // the digit being committed fills the store
    logic ptr_zero;    // emit pointer is at the least significant digit
  } utbd_stat_t;

  function automatic logic [6:0] glyph(input logic [3:0] d, input logic upper);
    glyph = upper ? GLYPH_UPPER[d] : GLYPH_LOWER[d];
  endfunction

endpackage

// ----- rtl/core/utbd_dp.sv -----
`timescale 1ns / 1ps

module utbd_dp import utbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] value,
  input  logic [7:0]  radix,
  input  logic        upper_case,
  input  utbd_cmd_t   cmd,
  output utbd_stat_t  stat,
  output logic [6:0]  digit_char,
  output logic        last_digit,
  output logic        bad_radix
);

  logic [DIV_W-1:0]   quo;
  logic [3:0]         rem;
  logic [4:0]         radix_r;
  logic               upper_r;
  logic [STEP_W-1:0]  step_cnt;
  logic [COUNT_W-1:0] count;
  logic [ADDR_W-1:0]  ptr;
  logic [3:0]         rd_digit;
  logic [3:0]         store [STORE_DEPTH];

  logic [STEP_BITS-1:0] chunk;
  logic [STEP_BITS-1:0] qbits;
  logic [4:0]           trial;
  logic [3:0]           part;
  logic [DIV_W-1:0]     quo_next;

  // Restoring division, one dividend bit per inner step, top chunk first.
  always_comb begin
    part  = rem;
    chunk = quo[DIV_W-1 -: STEP_BITS];
    qbits = '0;
    trial = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      trial = {part, chunk[i]};
      if (trial >= radix_r) begin
        trial    = trial - radix_r;
        qbits[i] = 1'b1;
      end
      part = trial[3:0];
    end
    quo_next = (quo << STEP_BITS) | DIV_W'(qbits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      count    <= '0;
    end else if (cmd.load) begin
      step_cnt <= '0;
      count    <= '0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + 1'b1;
    end else if (cmd.commit) begin
      step_cnt <= '0;
      count    <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo     <= DIV_W'(value[VALUE_WIDTH-1:0]);
      rem     <= '0;
      radix_r <= radix[4:0];
      upper_r <= upper_case;
    end else if (cmd.step) begin
      quo <= quo_next;
      rem <= part;
    end else if (cmd.commit) begin
      rem <= '0;
    end
    if (cmd.commit) begin
      ptr <= count[ADDR_W-1:0];
    end else if (cmd.advance) begin
      ptr <= ptr - 1'b1;
    end
  end

  // Digit store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      store[count[ADDR_W-1:0]] <= rem;
    end
    if (cmd.fetch) begin
      rd_digit <= store[ptr];
    end
  end

  always_comb begin
    stat.radix_bad  = (radix < 8'(RADIX_MIN)) || (radix > 8'(RADIX_MAX));
    stat.step_done  = (step_cnt == STEP_W'(STEPS - 1));
    stat.quo_zero   = (quo == '0);
    stat.count_full = (count == COUNT_W'(STORE_DEPTH - 1));
    stat.ptr_zero   = (ptr == '0);
  end

  assign digit_char = cmd.show_err ? 7'd0 : glyph(rd_digit, upper_r);
  assign last_digit = cmd.show_err | stat.ptr_zero;
  assign bad_radix  = cmd.show_err;

endmodule

// ----- rtl/core/utbd_ctrl.sv -----
`timescale 1ns / 1ps

module utbd_ctrl import utbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       digit_valid,
  input  logic       digit_ready,
  input  utbd_stat_t stat,
  output utbd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_SHOW   = 3'd4;
  localparam logic [2:0] S_ERR    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    item_ready  = 1'b0;
    digit_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.radix_bad ? S_ERR : S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (stat.step_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = (stat.quo_zero || stat.count_full) ? S_FETCH : S_DIV;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        digit_valid = 1'b1;
        if (digit_ready) begin
          if (stat.ptr_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      S_ERR: begin
        digit_valid  = 1'b1;
        cmd.show_err = 1'b1;
        if (digit_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/unsigned_to_base_digits_core.sv -----
`timescale 1ns / 1ps

// Unsigned value to ASCII digits in base 2..16. Each item transfer brings a
// value, a base and a letter-case flag; the core answers with one digit
// transfer per digit, most significant first, with last_digit set on the
// final one. Zero gives the single digit '0'. A base outside 2..16 gives one
// transfer with bad_radix and last_digit set and digit_char 0. Only the low
// VALUE_WIDTH bits of value count (package constant, 64 by default). One
// conversion runs at a time: item_ready is high only while the core is idle.
// Each digit takes STEPS divider steps and a commit (STEPS = 8 for a
// 64-bit value; the divider retires 8 dividend bits per cycle). Each digit
// is then emitted with one read of the digit store, after which the digit is
// shown until taken. A conversion gives at most 64 digits (base 2).
module unsigned_to_base_digits_core import utbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [63:0] value,
  input  logic [7:0]  radix,
  input  logic        upper_case,
  output logic        digit_valid,
  input  logic        digit_ready,
  output logic [6:0]  digit_char,
  output logic        last_digit,
  output logic        bad_radix
);

  utbd_cmd_t  cmd;
  utbd_stat_t stat;

  // Sequence the conversion: divide, commit digits, then walk them back out.
  utbd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .digit_valid (digit_valid),
    .digit_ready (digit_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Hold the quotient, divider, digit store and output glyph lookup.
  utbd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .radix      (radix),
    .upper_case (upper_case),
    .cmd        (cmd),
    .stat       (stat),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .bad_radix  (bad_radix)
  );

endmodule

// ----- rtl/core/utbd_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utbd_checker import utbd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic [7:0]  radix,
  input logic        digit_valid,
  input logic        digit_ready,
  input logic [6:0]  digit_char,
  input logic        last_digit,
  input logic        bad_radix
);

  logic bad_in;
  logic good_char;

  assign bad_in    = (radix < 8'(RADIX_MIN)) || (radix > 8'(RADIX_MAX));
  assign good_char = ((digit_char >= 7'h30) && (digit_char <= 7'h39)) ||
                     ((digit_char >= 7'h41) && (digit_char <= 7'h46)) ||
                     ((digit_char >= 7'h61) && (digit_char <= 7'h66));

  `ASSERT_NEXT(a_bad_base_reply, item_valid && item_ready && bad_in, digit_valid && bad_radix && last_digit, "bad base not answered next cycle")
  `ASSERT_IMPLY(a_err_shape, digit_valid && bad_radix, last_digit && (digit_char == 7'd0), "error result malformed")
  `ASSERT_IMPLY(a_char_range, digit_valid && !bad_radix, good_char, "digit outside the glyph set")
  `ASSERT_IMPLY(a_busy, digit_valid, !item_ready, "new item taken while digits pending")
  `ASSERT_NEXT(a_last_ends, digit_valid && digit_ready && last_digit, !digit_valid, "digits continue past the last one")

endmodule

bind unsigned_to_base_digits_core utbd_checker u_utbd_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Digit conversion check: items go in through a valid/ready channel and the
// digit transfers that come back are compared, field by field and in order,
// with the typed result or the predictor's (below), for each accepted item.
module tb;
  import utbd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 195;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [6:0] char_code;
    logic       is_last;
    logic       is_bad;
  } digit_t;

  // How a directed row gets its expected digits.
  typedef enum logic [1:0] {
    FROM_PREDICTOR,
    TYPED_DIGITS,
    TYPED_BAD_RADIX
  } row_kind_t;

  typedef struct {
    logic [63:0] value;
    logic [7:0]  radix;
    logic        upper;
    row_kind_t   kind;
    string       text;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [63:0] value = '0;
  logic [7:0]  radix = '0;
  logic        upper_case = 1'b0;
  logic        digit_valid;
  logic        digit_ready = 1'b0;
  logic [6:0]  digit_char;
  logic        last_digit;
  logic        bad_radix;

  // Predictor state: remainders of the last conversion and the working
  // quotient, kept as the block keeps them.
  logic [3:0]  remainder_store [STORE_DEPTH];
  logic [63:0] work_quotient = '0;

  digit_t      expected_digits [$];
  row_t        directed_rows [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;  // both sides run without idling while set

  unsigned_to_base_digits_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .value       (value),
    .radix       (radix),
    .upper_case  (upper_case),
    .digit_valid (digit_valid),
    .digit_ready (digit_ready),
    .digit_char  (digit_char),
    .last_digit  (last_digit),
    .bad_radix   (bad_radix)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Divide down by the base, then read the remainders back most significant
  // first and turn each into its ASCII character; a bad base gives the error.
  function automatic void predict_conversion(input logic [63:0] v, input logic [7:0] r,
                                             input logic u, ref digit_t digits [$]);
    logic [63:0] width_mask;
    logic [3:0]  rem;
    logic [6:0]  ch;
    int          n;
    digits.delete();
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      work_quotient = '0;
      digits.push_back('{char_code: 7'd0, is_last: 1'b1, is_bad: 1'b1});
      return;
    end
    width_mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
    work_quotient = v & width_mask;
    n = 0;
    // Zero still produces one digit.
    do begin
      remainder_store[n % STORE_DEPTH] = 4'(work_quotient % 64'(r));
      work_quotient = work_quotient / 64'(r);
      n++;
    end while (work_quotient != 0 && n < STORE_DEPTH);
    for (int k = 0; k < n; k++) begin
      rem = remainder_store[(n - 1 - k) % STORE_DEPTH];
      if (rem < 4'd10) ch = 7'h30 + 7'(rem);
      else ch = (u ? 7'h41 : 7'h61) + 7'(rem - 4'd10);
      digits.push_back('{char_code: ch, is_last: (k == n - 1), is_bad: 1'b0});
    end
  endfunction

  // Present one item, hold it until the transfer, then queue its digits.
  // Called at a rising edge; a zero gap keeps valid high into the next item.
  task automatic send_item(input logic [63:0] v, input logic [7:0] r, input logic u,
                           input row_kind_t kind, input string text);
    int     gap;
    digit_t predicted [$];
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    value <= v;
    radix <= r;
    upper_case <= u;
    do @(posedge clk); while (item_ready !== 1'b1);
    predict_conversion(v, r, u, predicted);
    case (kind)
      TYPED_DIGITS: begin
        for (int i = 0; i < text.len(); i++)
          expected_digits.push_back('{char_code: 7'(text[i]),
                                      is_last: (i == text.len() - 1), is_bad: 1'b0});
      end
      TYPED_BAD_RADIX: begin
        expected_digits.push_back('{char_code: 7'd0, is_last: 1'b1, is_bad: 1'b1});
      end
      default: begin
        foreach (predicted[i]) expected_digits.push_back(predicted[i]);
      end
    endcase
  endtask

  // Hold the sender until every queued digit has come back.
  task automatic drain_digits();
    item_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed table first, then random items.
  initial begin : stimulus
    logic [63:0] raw;
    logic [63:0] v;
    logic [7:0]  r;
    directed_rows = '{
      '{64'd0, 8'd10, 1'b0, TYPED_DIGITS, "0"},
      '{64'd0, 8'd2, 1'b1, TYPED_DIGITS, "0"},
      '{64'd0, 8'd16, 1'b1, TYPED_DIGITS, "0"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd16, 1'b1, TYPED_DIGITS, "FFFFFFFFFFFFFFFF"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd16, 1'b0, TYPED_DIGITS, "ffffffffffffffff"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd10, 1'b0, TYPED_DIGITS, "18446744073709551615"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd8, 1'b0, TYPED_DIGITS, "1777777777777777777777"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd2, 1'b0, FROM_PREDICTOR, ""},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd3, 1'b1, FROM_PREDICTOR, ""},
      '{64'h8000_0000_0000_0000, 8'd16, 1'b0, TYPED_DIGITS, "8000000000000000"},
      '{64'h8000_0000_0000_0000, 8'd2, 1'b1, FROM_PREDICTOR, ""},
      '{64'd5, 8'd2, 1'b0, TYPED_DIGITS, "101"},
      '{64'd36, 8'd6, 1'b0, TYPED_DIGITS, "100"},
      '{64'd10, 8'd11, 1'b1, TYPED_DIGITS, "A"},
      '{64'd10, 8'd11, 1'b0, TYPED_DIGITS, "a"},
      '{64'd255, 8'd16, 1'b1, TYPED_DIGITS, "FF"},
      '{64'h0123_4567_89AB_CDEF, 8'd16, 1'b0, TYPED_DIGITS, "123456789abcdef"},
      '{64'hFEDC_BA98_7654_3210, 8'd16, 1'b1, TYPED_DIGITS, "FEDCBA9876543210"},
      '{64'd12345, 8'd7, 1'b0, FROM_PREDICTOR, ""},
      '{64'h5555_5555_5555_5555, 8'd13, 1'b1, FROM_PREDICTOR, ""},
      '{64'd99, 8'd0, 1'b0, TYPED_BAD_RADIX, ""},
      '{64'd99, 8'd1, 1'b1, TYPED_BAD_RADIX, ""},
      '{64'd99, 8'd17, 1'b0, TYPED_BAD_RADIX, ""},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b1, TYPED_BAD_RADIX, ""},
      '{64'd0, 8'd128, 1'b0, TYPED_BAD_RADIX, ""}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].value, directed_rows[i].radix, directed_rows[i].upper,
                directed_rows[i].kind, directed_rows[i].text);
    drain_digits();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Pause the sender until the sink has caught up, at two points.
      if (n == 70 || n == 160) drain_digits();
      quiet = (n >= 100 && n < 130);
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = 64'($urandom_range(0, 40));
        2, 3:    v = raw;
        default: v = raw >> $urandom_range(1, 63);
      endcase
      // Mostly valid bases; the rest spread over both sides of the range.
      case ($urandom_range(0, 11))
        0:       r = 8'($urandom_range(0, RADIX_MIN - 1));
        1:       r = 8'($urandom_range(RADIX_MAX + 1, 255));
        default: r = 8'($urandom_range(RADIX_MIN, RADIX_MAX));
      endcase
      send_item(v, r, 1'($urandom_range(0, 1)), FROM_PREDICTOR, "");
    end
    quiet = 1'b0;

    item_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_digits.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Sink: unless quiet is set, hold ready low at random before taking each
  // digit, then compare the transfer with the oldest expectation.
  initial begin : digit_sink
    int     stall;
    digit_t want;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        digit_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      digit_ready <= 1'b1;
      do @(posedge clk); while (digit_valid !== 1'b1);
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected digit transfer: expected none, actual char %h last %b bad %b",
                 $realtime, digit_char, last_digit, bad_radix);
        mismatches++;
      end else begin
        want = expected_digits.pop_front();
        if (digit_char !== want.char_code) begin
          $display("%0t: digit_char expected %h actual %h", $realtime,
                   want.char_code, digit_char);
          mismatches++;
        end
        if (last_digit !== want.is_last) begin
          $display("%0t: last_digit expected %b actual %b", $realtime,
                   want.is_last, last_digit);
          mismatches++;
        end
        if (bad_radix !== want.is_bad) begin
          $display("%0t: bad_radix expected %b actual %b", $realtime,
                   want.is_bad, bad_radix);
          mismatches++;
        end
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
